// ===== hw/rtl/stds_pkg.sv =====
// Shared types, codes and character decode tables for the scrolling marquee scanner.
package stds_pkg;

	// Item actions
	typedef enum logic [1:0] {
		ACT_SCAN  = 2'd0,
		ACT_STEP  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTH = 2'd2;

	// Field and state widths fixed by the interface
	localparam int PERIOD_W = 10;
	localparam int LEN_W    = 6;
	localparam int WIN_W    = 6;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd512;
	localparam logic [7:0]          CHAR_BLANK   = 8'h20;
	localparam logic [6:0]          SEG_DASH     = 7'h40;
	localparam logic [6:0]          SEG_OFF      = 7'h00;

	// Local speed presets, in step ticks per window move
	localparam logic [PERIOD_W-1:0] PRESET_PERIODS [4] = '{10'd512, 10'd128, 10'd48, 10'd16};

	localparam logic [6:0] DIGIT_SEGS [10] = '{
		7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
	};

	// U, V and W share one pattern
	localparam logic [6:0] LETTER_SEGS [26] = '{
		7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h30, 7'h1E, 7'h75, 7'h38,
		7'h37, 7'h54, 7'h3F, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78, 7'h3E, 7'h3E, 7'h3E, 7'h76,
		7'h6E, 7'h5B
	};

	typedef struct packed {
		logic [1:0] action;
		logic       key_direction;
		logic       key_speed;
		logic [4:0] char_index;
		logic [7:0] char_value;
	} item_t;

	typedef struct packed {
		logic [6:0] segments;
		logic [7:0] digit_enable;
		logic [7:0] led_drive;
		logic [4:0] window_position;
	} result_t;

	// Map an ASCII code to a segment pattern, bit 0 is segment a
	function automatic logic [6:0] decode_char(input logic [7:0] c);
		logic [6:0] seg;
		seg = SEG_OFF;
		case (c) inside
			[8'h30:8'h39]: seg = DIGIT_SEGS[4'(c - 8'h30)];
			[8'h41:8'h5a]: seg = LETTER_SEGS[5'(c - 8'h41)];
			[8'h61:8'h7a]: seg = LETTER_SEGS[5'(c - 8'h61)];
			8'h2d:         seg = SEG_DASH;
			default:       seg = SEG_OFF;
		endcase
		return seg;
	endfunction

endpackage

// ===== hw/rtl/stds_text_store.sv =====
// Character store: synchronous RAM with per-entry fill bits so unwritten slots read blank.
module stds_text_store import stds_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] filled_q;
	logic [7:0]       rdata_q;
	logic             rfilled_q;

	// Write and read the array; read data is registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Track which slots have been written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q  <= '0;
			rfilled_q <= 1'b0;
		end else begin
			if (wr_en) begin
				filled_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rfilled_q <= filled_q[rd_addr];
			end
		end
	end

	assign rd_data = rfilled_q ? rdata_q : CHAR_BLANK;

endmodule

// ===== hw/rtl/scrolling_text_display_scanner_unit.sv =====
// Top level of the scrolling seven-segment marquee scanner.
// The block accepts one transaction per clock cycle while the output is not stalled, and returns
// exactly one result per transaction: the synchronous read of the character store and the
// stage-1 registers load at the accepting edge, and the output register loads from stage 1
// when it is free. Window, scan digit, step counter and key history update at acceptance, so a
// scan tick right after a write or a step sees their effect. The character store reads blank
// from reset through per-slot fill bits, so no clearing pass is needed and the block is ready
// as soon as reset is released.
module scrolling_text_display_scanner_unit import stds_pkg::*; #(
	parameter int TEXT_DEPTH  = 32,
	parameter int DIGIT_COUNT = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result
);

	localparam int AW  = $clog2(TEXT_DEPTH);
	localparam int SDW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [SDW-1:0] DIGIT_LAST = SDW'(DIGIT_COUNT - 1);

	// Largest window start for a given text length
	function automatic logic [WIN_W-1:0] window_max_of(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] used;
		used = (9'(len) > 9'(TEXT_DEPTH)) ? LEN_W'(TEXT_DEPTH) : len;
		return (7'(used) > 7'(DIGIT_COUNT)) ? WIN_W'(used - LEN_W'(DIGIT_COUNT)) : '0;
	endfunction

	// Configuration registers
	logic                mode_q;
	logic [PERIOD_W-1:0] remote_period_q;
	logic [LEN_W-1:0]    text_length_q;

	// Scroll state
	logic [WIN_W-1:0]    win_q, win_d;
	logic                backward_q, backward_d;
	logic [SDW-1:0]      scan_q, scan_d;
	logic [PERIOD_W-1:0] step_q, step_d;
	logic [1:0]          preset_q, preset_d;
	logic                prev_dir_q, prev_dir_d;
	logic                prev_spd_q, prev_spd_d;

	// Pipeline
	logic             s1_valid_q;
	logic             scan_s1;
	logic             in_range_s1;
	logic [7:0]       enable_s1;
	logic [WIN_W-1:0] win_s1;
	logic             out_valid_q;
	result_t          result_q;

	logic             accept;
	logic             out_free;
	logic             s1_move;
	logic [LEN_W-1:0] used_len;
	logic [WIN_W-1:0] win_max;
	logic [WIN_W-1:0] win_inc;
	logic [6:0]       pos;
	logic             in_range;
	logic [15:0]      enable_wide;
	logic [PERIOD_W-1:0] period;
	logic [PERIOD_W-1:0] step_inc;
	logic             slot_ok;
	logic             store_wr;
	logic             store_rd;
	logic [7:0]       store_rdata;
	logic             cfg_clamp;
	logic [WIN_W-1:0] cfg_win_max;
	logic [7:0]       shown_char;
	result_t          result_d;

	// Handshake: advance stage 1 into the output register whenever it is free
	assign out_free   = !out_valid_q || result_ready;
	assign s1_move    = s1_valid_q && out_free;
	assign item_ready = !s1_valid_q || out_free;
	assign accept     = item_valid && item_ready;

	// Address of the scanned character
	assign used_len    = (9'(text_length_q) > 9'(TEXT_DEPTH)) ? LEN_W'(TEXT_DEPTH) : text_length_q;
	assign win_max     = window_max_of(text_length_q);
	assign win_inc     = win_q + WIN_W'(1);
	assign pos         = 7'(win_q) + 7'(scan_q);
	assign in_range    = pos < 7'(used_len);
	assign enable_wide = 16'(1) << scan_q;
	assign step_inc    = step_q + PERIOD_W'(1);
	assign slot_ok     = 9'(item.char_index) < 9'(TEXT_DEPTH);

	// Next scroll state for the accepted transaction
	always_comb begin
		win_d      = win_q;
		backward_d = backward_q;
		scan_d     = scan_q;
		step_d     = step_q;
		preset_d   = preset_q;
		prev_dir_d = prev_dir_q;
		prev_spd_d = prev_spd_q;
		period     = remote_period_q;
		store_wr   = 1'b0;
		store_rd   = 1'b0;
		if (accept) begin
			case (action_t'(item.action))
				ACT_SCAN: begin
					store_rd = in_range;
					scan_d   = (scan_q == DIGIT_LAST) ? '0 : scan_q + SDW'(1);
				end
				ACT_STEP: begin
					if (!mode_q) begin
						if (prev_dir_q && !item.key_direction) begin
							backward_d = !backward_q;
						end
						if (prev_spd_q && !item.key_speed) begin
							preset_d = preset_q + 2'd1;
						end
					end
					prev_dir_d = item.key_direction;
					prev_spd_d = item.key_speed;
					period     = mode_q ? remote_period_q : PRESET_PERIODS[preset_d];
					if (step_inc >= period) begin
						step_d = '0;
						if (backward_d) begin
							win_d = (win_q == '0) ? win_max : win_q - WIN_W'(1);
						end else begin
							win_d = (win_inc > win_max) ? '0 : win_inc;
						end
					end else begin
						step_d = step_inc;
					end
				end
				ACT_WRITE: begin
					store_wr = slot_ok;
				end
				default: begin
				end
			endcase
		end
	end

	// Pull the window down when a shorter text length is written
	assign cfg_win_max = window_max_of(cfg_data[LEN_W-1:0]);
	assign cfg_clamp   = cfg_write && (cfg_index == REG_LENGTH) && (win_q > cfg_win_max);

	// Hold configuration and scroll state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= 1'b0;
			remote_period_q <= PERIOD_RESET;
			text_length_q   <= '0;
			win_q           <= '0;
			backward_q      <= 1'b0;
			scan_q          <= '0;
			step_q          <= '0;
			preset_q        <= '0;
			prev_dir_q      <= 1'b1;
			prev_spd_q      <= 1'b1;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_MODE:   mode_q          <= cfg_data[0];
					REG_PERIOD: remote_period_q <= cfg_data[PERIOD_W-1:0];
					REG_LENGTH: text_length_q   <= cfg_data[LEN_W-1:0];
					default: begin
					end
				endcase
			end
			win_q      <= cfg_clamp ? cfg_win_max : win_d;
			backward_q <= backward_d;
			scan_q     <= scan_d;
			step_q     <= step_d;
			preset_q   <= preset_d;
			prev_dir_q <= prev_dir_d;
			prev_spd_q <= prev_spd_d;
		end
	end

	stds_text_store #(
		.DEPTH (TEXT_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (store_wr),
		.wr_addr (AW'(item.char_index)),
		.wr_data (item.char_value),
		.rd_en   (store_rd),
		.rd_addr (AW'(pos)),
		.rd_data (store_rdata)
	);

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage 1 payload: what the result needs besides the store data
	always_ff @(posedge clk) begin
		if (accept) begin
			scan_s1     <= (action_t'(item.action) == ACT_SCAN);
			in_range_s1 <= in_range;
			enable_s1   <= (action_t'(item.action) == ACT_SCAN) ? enable_wide[7:0] : '0;
			win_s1      <= cfg_clamp ? cfg_win_max : win_d;
		end
		if (s1_move) begin
			result_q <= result_d;
		end
	end

	// Decode the scanned character and build the result
	always_comb begin
		shown_char               = in_range_s1 ? store_rdata : CHAR_BLANK;
		result_d.segments        = scan_s1 ? decode_char(shown_char) : SEG_OFF;
		result_d.digit_enable    = enable_s1;
		result_d.led_drive       = ~(8'd1 << (3'd7 - win_s1[2:0]));
		result_d.window_position = win_s1[4:0];
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

// ===== tb/sv/tb_scrolling_text_display_scanner_unit.sv =====
// Self-checking testbench for the scrolling seven-segment marquee scanner unit.
`timescale 1ns / 1ps

module tb_scrolling_text_display_scanner_unit;
	import stds_pkg::*;

	localparam int STORE_DEPTH = 32;
	localparam int DIGITS      = 8;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 162;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 400;
	localparam int HOLD_AFTER  = 700;
	localparam int SETTLE      = 10;
	localparam int PRINT_CAP   = 100;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	// Segment patterns, bit 0 is segment a
	localparam logic [6:0] NUMERAL_GLYPHS [10] = '{
		7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
	};
	localparam logic [6:0] ALPHA_GLYPHS [26] = '{
		7'h77, 7'h7c, 7'h39, 7'h5e, 7'h79, 7'h71, 7'h3d, 7'h76, 7'h30, 7'h1e, 7'h75, 7'h38,
		7'h37, 7'h54, 7'h3f, 7'h73, 7'h67, 7'h50, 7'h6d, 7'h78, 7'h3e, 7'h3e, 7'h3e, 7'h76,
		7'h6e, 7'h5b
	};
	localparam logic [9:0] SPEED_STEPS [4] = '{10'd512, 10'd128, 10'd48, 10'd16};

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		item_t                  stim;
		bit                     typed;
		result_t                want;
		logic [CFG_INDEX_W-1:0] reg_index;
		logic [CFG_DATA_W-1:0]  reg_value;
	} script_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   item_valid;
	logic                   item_ready;
	item_t                  item;
	logic                   result_valid;
	logic                   result_ready;
	result_t                result;

	// Shadow copy of the marquee state and its registers
	logic [7:0]  shadow_text [STORE_DEPTH];
	logic [4:0]  shadow_window;
	logic        shadow_backward;
	logic [2:0]  shadow_digit;
	logic [9:0]  shadow_steps;
	logic [1:0]  shadow_preset;
	logic        shadow_prev_dir;
	logic        shadow_prev_speed;
	logic        shadow_mode;
	logic [9:0]  shadow_period;
	logic [5:0]  shadow_length;

	result_t     expected_frames [$];
	script_row_t script [$];

	bit calm;
	bit jitter;
	int mismatches;
	int results_checked;
	int n_scan, n_step, n_write, n_unused;
	int settings_used;
	int window_moves, window_wraps;

	scrolling_text_display_scanner_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Map a character code to its segment pattern
	function automatic logic [6:0] glyph_of(input logic [7:0] code);
		if (code >= 8'h30 && code <= 8'h39) return NUMERAL_GLYPHS[4'(code - 8'h30)];
		if (code >= 8'h41 && code <= 8'h5a) return ALPHA_GLYPHS[5'(code - 8'h41)];
		if (code >= 8'h61 && code <= 8'h7a) return ALPHA_GLYPHS[5'(code - 8'h61)];
		if (code == 8'h2d) return 7'h40;
		return 7'h00;
	endfunction

	function automatic int visible_length();
		return (shadow_length > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_length);
	endfunction

	function automatic int window_limit();
		return (visible_length() > DIGITS) ? visible_length() - DIGITS : 0;
	endfunction

	// Advance the shadow state by one transaction and return the result it should give
	function automatic result_t marquee_predict(input item_t it);
		result_t    r;
		int         pos;
		int         lim;
		logic [7:0] code;
		logic [9:0] period;
		r = '0;
		case (action_t'(it.action))
			ACT_SCAN: begin
				pos = int'(shadow_window) + int'(shadow_digit);
				code = (pos < visible_length()) ? shadow_text[5'(pos)] : CHAR_BLANK;
				r.segments = glyph_of(code);
				r.digit_enable = 8'h01 << shadow_digit;
				shadow_digit = shadow_digit + 3'd1;
			end
			ACT_STEP: begin
				if (!shadow_mode) begin
					if (shadow_prev_dir && !it.key_direction) shadow_backward = ~shadow_backward;
					if (shadow_prev_speed && !it.key_speed) shadow_preset = shadow_preset + 2'd1;
				end
				shadow_prev_dir = it.key_direction;
				shadow_prev_speed = it.key_speed;
				period = shadow_mode ? shadow_period : SPEED_STEPS[shadow_preset];
				shadow_steps = shadow_steps + 10'd1;
				if (shadow_steps >= period) begin
					lim = window_limit();
					shadow_steps = '0;
					window_moves++;
					if (shadow_backward) begin
						if (shadow_window == 0) begin
							shadow_window = 5'(lim);
							window_wraps++;
						end else begin
							shadow_window = shadow_window - 5'd1;
						end
					end else begin
						shadow_window = shadow_window + 5'd1;
						if (shadow_window > lim) begin
							shadow_window = '0;
							window_wraps++;
						end
					end
				end
			end
			ACT_WRITE: shadow_text[it.char_index] = it.char_value;
			default: ;
		endcase
		r.led_drive = ~(8'h80 >> shadow_window[2:0]);
		r.window_position = shadow_window;
		return r;
	endfunction

	function automatic item_t mk_item(input action_t act, input logic kd, input logic ks,
			input logic [4:0] slot, input logic [7:0] code);
		item_t it;
		it.action = act;
		it.key_direction = kd;
		it.key_speed = ks;
		it.char_index = slot;
		it.char_value = code;
		return it;
	endfunction

	// Result with the window still at its reset position
	function automatic result_t at_origin(input logic [6:0] segs, input logic [7:0] en);
		result_t r;
		r.segments = segs;
		r.digit_enable = en;
		r.led_drive = 8'h7f;
		r.window_position = 5'd0;
		return r;
	endfunction

	function automatic script_row_t item_row(input item_t stim, input bit typed,
			input result_t want);
		script_row_t row;
		row.kind = ROW_ITEM;
		row.stim = stim;
		row.typed = typed;
		row.want = want;
		row.reg_index = '0;
		row.reg_value = '0;
		return row;
	endfunction

	function automatic script_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		script_row_t row;
		row.kind = ROW_REG;
		row.stim = '0;
		row.typed = 1'b0;
		row.want = '0;
		row.reg_index = idx;
		row.reg_value = value;
		return row;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Offer one transaction, hold it until accepted, then queue its expected result
	task automatic offer(input item_t it, input bit typed, input result_t want);
		result_t predicted;
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		predicted = marquee_predict(it);
		expected_frames.push_back(typed ? want : predicted);
		case (action_t'(it.action))
			ACT_SCAN:  n_scan++;
			ACT_STEP:  n_step++;
			ACT_WRITE: n_write++;
			default:   n_unused++;
		endcase
	endtask

	task automatic maybe_pause();
		if (!calm && jitter && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_frames.size() != 0);
	endtask

	task automatic poke_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_MODE:   shadow_mode = value[0];
			REG_PERIOD: shadow_period = value;
			REG_LENGTH: begin
				shadow_length = value[5:0];
				if (shadow_window > window_limit()) shadow_window = 5'(window_limit());
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Result side: check each transaction, then pick the next ready level
	initial begin : result_side
		int      idle_left;
		int      hold_left;
		int      span_left;
		bit      stall_on;
		bit      held;
		result_t want;
		idle_left = 0;
		hold_left = 0;
		span_left = 0;
		stall_on = 1'b0;
		held = 1'b0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				results_checked++;
				if (expected_frames.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %h", result));
				end else begin
					want = expected_frames.pop_front();
					if (result.segments !== want.segments)
						flag_mismatch($sformatf("segments got %h want %h",
							result.segments, want.segments));
					if (result.digit_enable !== want.digit_enable)
						flag_mismatch($sformatf("digit_enable got %h want %h",
							result.digit_enable, want.digit_enable));
					if (result.led_drive !== want.led_drive)
						flag_mismatch($sformatf("led_drive got %h want %h",
							result.led_drive, want.led_drive));
					if (result.window_position !== want.window_position)
						flag_mismatch($sformatf("window_position got %0d want %0d",
							result.window_position, want.window_position));
				end
			end
			// switch stalling on and off in long spans
			if (span_left == 0) begin
				stall_on = ($urandom_range(0, 3) != 0);
				span_left = $urandom_range(50, 300);
			end else begin
				span_left--;
			end
			if (!held && results_checked >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				result_ready <= 1'b0;
			end else if (stall_on && !calm && $urandom_range(0, 7) == 0) begin
				idle_left = $urandom_range(1, 12) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Abort when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_write)
				quiet = 0;
			else if (arst_n)
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles", quiet);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int          phase;
		int          sent;
		int          k;
		int          n;
		int          pick;
		bit          paused;
		logic [4:0]  slot;
		logic [7:0]  code;
		logic        p_mode;
		logic [9:0]  p_period;
		logic [5:0]  p_length;
		item_t       it;

		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_valid <= 1'b0;
		item <= '0;
		calm = 1'b0;
		jitter = 1'b1;
		paused = 1'b0;

		// reset state of the shadow copy
		foreach (shadow_text[i]) shadow_text[i] = CHAR_BLANK;
		shadow_window = '0;
		shadow_backward = 1'b0;
		shadow_digit = '0;
		shadow_steps = '0;
		shadow_preset = '0;
		shadow_prev_dir = 1'b1;
		shadow_prev_speed = 1'b1;
		shadow_mode = 1'b0;
		shadow_period = PERIOD_RESET;
		shadow_length = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: reset view, unused action, decode extremes, register corners
		script.push_back(item_row(mk_item(ACT_SCAN, 1, 1, 5'd0, 8'h00), 1,
			at_origin(7'h00, 8'h01)));
		script.push_back(item_row(mk_item(ACT_NONE, 0, 0, 5'd31, 8'hff), 1,
			at_origin(7'h00, 8'h00)));
		script.push_back(item_row(mk_item(ACT_WRITE, 1, 1, 5'd0, 8'h00), 1,
			at_origin(7'h00, 8'h00)));
		script.push_back(item_row(mk_item(ACT_WRITE, 1, 1, 5'd1, "-"), 1,
			at_origin(7'h00, 8'h00)));
		script.push_back(item_row(mk_item(ACT_WRITE, 1, 1, 5'd2, "9"), 1,
			at_origin(7'h00, 8'h00)));
		script.push_back(item_row(mk_item(ACT_WRITE, 1, 1, 5'd3, "A"), 1,
			at_origin(7'h00, 8'h00)));
		script.push_back(item_row(mk_item(ACT_WRITE, 1, 1, 5'd4, "z"), 1,
			at_origin(7'h00, 8'h00)));
		script.push_back(item_row(mk_item(ACT_WRITE, 1, 1, 5'd5, "0"), 1,
			at_origin(7'h00, 8'h00)));
		script.push_back(item_row(mk_item(ACT_WRITE, 1, 1, 5'd6, "Z"), 1,
			at_origin(7'h00, 8'h00)));
		script.push_back(item_row(mk_item(ACT_WRITE, 0, 0, 5'd31, 8'hff), 1,
			at_origin(7'h00, 8'h00)));
		// length above the store depth counts as a full store
		script.push_back(reg_row(REG_LENGTH, 10'd33));
		script.push_back(item_row(mk_item(ACT_SCAN, 0, 1, 5'd9, 8'h11), 1,
			at_origin(7'h40, 8'h02)));
		script.push_back(item_row(mk_item(ACT_SCAN, 1, 0, 5'd22, 8'h80), 1,
			at_origin(7'h6f, 8'h04)));
		script.push_back(item_row(mk_item(ACT_SCAN, 0, 0, 5'd31, 8'hff), 1,
			at_origin(7'h77, 8'h08)));
		script.push_back(item_row(mk_item(ACT_SCAN, 1, 1, 5'd0, 8'h00), 1,
			at_origin(7'h5b, 8'h10)));
		script.push_back(item_row(mk_item(ACT_SCAN, 1, 1, 5'd16, 8'h41), 1,
			at_origin(7'h3f, 8'h20)));
		script.push_back(item_row(mk_item(ACT_SCAN, 1, 1, 5'd1, 8'h7f), 1,
			at_origin(7'h5b, 8'h40)));
		// slot never written still reads blank
		script.push_back(item_row(mk_item(ACT_SCAN, 1, 1, 5'd2, 8'h02), 1,
			at_origin(7'h00, 8'h80)));
		script.push_back(item_row(mk_item(ACT_SCAN, 1, 1, 5'd4, 8'h04), 1,
			at_origin(7'h00, 8'h01)));
		// remote mode with zero period: keys recorded but ignored, every step moves
		script.push_back(reg_row(REG_MODE, 10'd1));
		script.push_back(reg_row(REG_PERIOD, 10'd0));
		script.push_back(item_row(mk_item(ACT_STEP, 0, 0, 5'd0, 8'h00), 0, '0));
		script.push_back(item_row(mk_item(ACT_STEP, 1, 1, 5'd0, 8'h00), 0, '0));
		// back to local keys: both keys fall at once
		script.push_back(reg_row(REG_MODE, 10'd0));
		script.push_back(reg_row(REG_PERIOD, 10'd1000));
		script.push_back(reg_row(REG_UNUSED, 10'h3ff));
		script.push_back(item_row(mk_item(ACT_STEP, 0, 0, 5'd0, 8'h00), 0, '0));
		script.push_back(item_row(mk_item(ACT_STEP, 1, 1, 5'd0, 8'h00), 0, '0));
		// shrinking the text pulls the window down
		script.push_back(reg_row(REG_LENGTH, 10'd0));
		script.push_back(item_row(mk_item(ACT_SCAN, 0, 1, 5'd3, 8'h33), 0, '0));
		script.push_back(item_row(mk_item(ACT_WRITE, 1, 0, 5'd16, 8'h55), 0, '0));

		foreach (script[r]) begin
			if (script[r].kind == ROW_REG) begin
				drain();
				poke_register(script[r].reg_index, script[r].reg_value);
			end else begin
				maybe_pause();
				offer(script[r].stim, script[r].typed, script[r].want);
			end
		end
		settings_used = 4;

		// random phases, each under its own register setting
		for (phase = 0; phase < PHASES; phase++) begin
			calm = (phase == PHASES - 1);
			drain();
			case (phase)
				0: begin p_mode = 1'b0; p_period = 10'd1023; p_length = 6'd32; end
				1: begin p_mode = 1'b1; p_period = 10'd1000; p_length = 6'd20; end
				2: begin p_mode = 1'b1; p_period = 10'd3;    p_length = 6'd20; end
				3: begin p_mode = 1'b1; p_period = 10'd0;    p_length = 6'd9;  end
				4: begin p_mode = 1'b0; p_period = 10'd1;    p_length = 6'd63; end
				5: begin p_mode = 1'b1; p_period = 10'd1;    p_length = 6'd8;  end
				6: begin p_mode = 1'b1; p_period = 10'd7;    p_length = 6'd0;  end
				7: begin p_mode = 1'b0; p_period = 10'd500;  p_length = 6'd33; end
				default: begin
					p_mode = 1'($urandom_range(0, 1));
					p_period = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
						: 10'($urandom_range(0, 24));
					p_length = 6'($urandom_range(0, 63));
				end
			endcase
			// unused upper data bits carry noise
			poke_register(REG_MODE, {9'($urandom), p_mode});
			poke_register(REG_PERIOD, p_period);
			poke_register(REG_LENGTH, {4'($urandom), p_length});
			settings_used++;

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// hold off mid-phase until the pipe is empty
				if (phase == 5 && !paused && sent >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					drain();
				end
				jitter = !calm && ($urandom_range(0, 3) != 0);
				pick = $urandom_range(0, 9);
				if (pick < 3) begin
					// one full sweep of the digits
					for (k = 0; k < DIGITS; k++) begin
						maybe_pause();
						offer(mk_item(ACT_SCAN, 1'($urandom), 1'($urandom), 5'($urandom),
							8'($urandom)), 0, '0);
						sent++;
					end
				end else if (pick < 6) begin
					// run of step ticks, keys mostly released
					n = $urandom_range(1, 24);
					for (k = 0; k < n; k++) begin
						maybe_pause();
						offer(mk_item(ACT_STEP, 1'($urandom_range(0, 3) != 0),
							1'($urandom_range(0, 3) != 0), 5'($urandom), 8'($urandom)), 0, '0);
						sent++;
					end
				end else if (pick < 8) begin
					// spell a word into consecutive slots
					slot = 5'($urandom);
					n = $urandom_range(1, 10);
					for (k = 0; k < n; k++) begin
						case ($urandom_range(0, 9))
							0, 1, 2: code = 8'h30 + 8'($urandom_range(0, 9));
							3, 4, 5: code = 8'h41 + 8'($urandom_range(0, 25));
							6, 7:    code = 8'h61 + 8'($urandom_range(0, 25));
							8:       code = 8'h2d;
							default: code = 8'($urandom);
						endcase
						maybe_pause();
						offer(mk_item(ACT_WRITE, 1'($urandom), 1'($urandom), slot, code), 0, '0);
						slot = slot + 5'd1;
						sent++;
					end
				end else begin
					// fully random transaction, unused action included
					it = item_t'($urandom);
					maybe_pause();
					offer(it, 0, '0);
					if (action_t'(it.action) != ACT_NONE) sent++;
				end
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d scan, %0d step, %0d write, %0d unused transactions, %0d settings",
			n_scan, n_step, n_write, n_unused, settings_used);
		$display("window moved %0d times with %0d wraps; %0d results compared, %0d mismatches",
			window_moves, window_wraps, results_checked, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
